@@ hw/rtl/ccp_pkg.sv @@
// shared types and constants for the cat command parser
// no dependencies
`timescale 1ns / 1ps
package ccp_pkg;
    localparam int BufferDepth = 64;
    localparam int CntW = $clog2(BufferDepth + 1);
    localparam int FreqDigits = 11;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] current_freq;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        logic        freq_update;
        logic [31:0] new_freq;
        logic        transmit_request;
        logic        receive_request;
    } t_out_item;

    typedef enum logic [2:0] {
        CMD_SETF, CMD_QUERYF, CMD_RX, CMD_TX, CMD_TY, CMD_IF, CMD_BAD
    } t_cmd_kind;

    // command handed from front to back
    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  c1;
        logic [31:0] freq;
        logic        tx_state;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PARSE, ST_CONV, ST_EMIT
    } t_back_state;

    localparam logic [7:0] ChSemi = 8'h3B;
endpackage

@@ hw/rtl/ccp_front.sv @@
// front part: buffers bytes, parses set-frequency digits, classifies commands
// depends on ccp_pkg
`timescale 1ns / 1ps
module ccp_front import ccp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    output logic     o_cmd_valid,
    input  logic     i_cmd_stall,
    output t_cmd     o_cmd
);
    logic [CntW-1:0] r_fill, n_fill;
    logic [7:0]      r_c0, r_c1;
    logic [32:0]     r_acc;   // running set-frequency value, bit 32 = saturated
    logic            r_dig_on;
    logic            r_tx, r_cmd_valid;
    t_cmd            r_cmd;
    logic            acc_take;
    logic [7:0]      ch;
    logic [3:0]      dig;
    logic            is_dig;
    logic [36:0]     mul;
    logic            accept;
    t_cmd_kind       kind;

    assign accept = i_valid && !o_stall;
    assign o_stall = r_cmd_valid && i_cmd_stall;
    assign ch = i_item.rx_byte;
    assign is_dig = ch >= 8'h30 && ch <= 8'h39;
    assign dig = 4'(ch - 8'h30);
    assign mul = {4'd0, r_acc[31:0]} * 37'd10 + {33'd0, dig};
    assign acc_take = r_fill >= CntW'(2) && r_dig_on && is_dig;

    always_comb begin
        priority if (r_c0 == "F" && r_fill == CntW'(13)) kind = CMD_SETF;
        else if (r_c0 == "F" && r_fill == CntW'(2)) kind = CMD_QUERYF;
        else if (r_fill == CntW'(2) && r_c0 == "R" && r_c1 == "X") kind = CMD_RX;
        else if (r_fill == CntW'(2) && r_c0 == "T" && r_c1 == "X") kind = CMD_TX;
        else if (r_fill == CntW'(2) && r_c0 == "T" && r_c1 == "Y") kind = CMD_TY;
        else if (r_fill == CntW'(2) && r_c0 == "I" && r_c1 == "F") kind = CMD_IF;
        else kind = CMD_BAD;
    end

    always_comb begin
        n_fill = r_fill;
        if (ch == ChSemi) n_fill = '0;
        else if (r_fill < CntW'(BufferDepth)) n_fill = r_fill + CntW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (accept && ch != ChSemi && r_fill < CntW'(BufferDepth)) begin
            if (r_fill == CntW'(0)) r_c0 <= ch;
            if (r_fill == CntW'(1)) r_c1 <= ch;
        end
        if (accept) begin
            if (ch == ChSemi || r_fill == CntW'(0)) begin
                r_acc <= '0;
                r_dig_on <= 1'b1;
            end else if (r_fill >= CntW'(2) && r_fill < CntW'(BufferDepth)) begin
                if (acc_take) begin
                    r_acc <= (r_acc[32] || mul[36:32] != 5'd0) ? {1'b1, 32'hFFFF_FFFF}
                                                                : {1'b0, mul[31:0]};
                end else begin
                    r_dig_on <= 1'b0;
                end
            end
        end
        if (accept && ch == ChSemi) begin
            r_cmd.kind <= kind;
            r_cmd.c1 <= r_c1;
            r_cmd.freq <= (kind == CMD_SETF) ? r_acc[31:0] : i_item.current_freq;
            r_cmd.tx_state <= r_tx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_tx <= 1'b0;
            r_cmd_valid <= 1'b0;
        end else begin
            if (accept) r_fill <= n_fill;
            if (accept && ch == ChSemi) begin
                r_cmd_valid <= 1'b1;
                if (kind == CMD_RX) r_tx <= 1'b0;
                if (kind == CMD_TX) r_tx <= 1'b1;
            end else if (!i_cmd_stall) begin
                r_cmd_valid <= 1'b0;
            end
        end
    end

    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd = r_cmd;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CntW'(BufferDepth)) else $error("fill over depth");
    a_semi_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && ch == ChSemi |=> r_fill == '0 && r_cmd_valid) else $error("semi");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd_valid && i_cmd_stall |=> r_cmd_valid && $stable(r_cmd)) else $error("hold");
`endif
endmodule

@@ hw/rtl/ccp_back.sv @@
// back part: converts frequency to decimal and sends answer beats
// depends on ccp_pkg
`timescale 1ns / 1ps
module ccp_back import ccp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_stall,
    input  t_cmd      i_cmd,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    t_back_state r_state, n_state;
    t_cmd        r_cmd;
    logic [31:0] r_val;
    logic [3:0]  r_dig [FreqDigits];
    logic [3:0]  r_dcnt;
    logic [5:0]  r_idx, r_len;
    logic        r_valid;
    t_out_item   r_item, n_item;
    logic [5:0]  len;
    logic        take, out_free;
    logic [31:0] q;
    logic [3:0]  rem;
    logic [63:0] prod;

    assign out_free = !r_valid || !i_stall;
    assign take = r_state == ST_IDLE && i_cmd_valid;
    assign o_cmd_stall = r_state != ST_IDLE;
    // divide by ten through reciprocal
    assign prod = {32'd0, r_val} * 64'hCCCC_CCCD;
    assign q = {3'd0, prod[63:35]};
    assign rem = 4'(r_val - q * 32'd10);

    always_comb begin
        unique case (r_cmd.kind)
            CMD_QUERYF: len = 6'd15;
            CMD_TY:     len = 6'd7;
            CMD_IF:     len = 6'd38;
            CMD_BAD:    len = 6'd3;
            default:    len = 6'd1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_cmd_valid) n_state = ST_PARSE;
            ST_PARSE: n_state = ST_CONV;
            ST_CONV:  if (r_dcnt == 4'd0) n_state = ST_EMIT;
            ST_EMIT:  if (out_free && r_idx == r_len - 6'd1) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        logic [3:0] di;
        logic [5:0] k;
        di = '0;
        k = r_idx;
        n_item = '0;
        n_item.last = (r_idx == r_len - 6'd1);
        n_item.byte_valid = 1'b1;
        unique case (r_cmd.kind)
            CMD_SETF: begin
                n_item.byte_valid = 1'b0;
                n_item.freq_update = 1'b1;
                n_item.new_freq = r_cmd.freq;
            end
            CMD_RX: begin n_item.byte_valid = 1'b0; n_item.receive_request = 1'b1; end
            CMD_TX: begin n_item.byte_valid = 1'b0; n_item.transmit_request = 1'b1; end
            CMD_TY: begin
                unique case (k)
                    6'd0: n_item.out_byte = "T";
                    6'd1: n_item.out_byte = "Y";
                    6'd2, 6'd3: n_item.out_byte = "0";
                    6'd4: n_item.out_byte = "1";
                    6'd5: n_item.out_byte = ";";
                    default: n_item.out_byte = 8'h0A;
                endcase
            end
            CMD_QUERYF: begin
                if (k == 6'd0) n_item.out_byte = "F";
                else if (k == 6'd1) n_item.out_byte = r_cmd.c1;
                else if (k < 6'd13) begin
                    di = r_dig[4'(k - 6'd2)];
                    n_item.out_byte = 8'h30 + {4'd0, di};
                end else if (k == 6'd13) n_item.out_byte = ";";
                else n_item.out_byte = 8'h0A;
            end
            CMD_IF: begin
                if (k == 6'd0) n_item.out_byte = "I";
                else if (k == 6'd1) n_item.out_byte = "F";
                else if (k < 6'd13) begin
                    di = r_dig[4'(k - 6'd2)];
                    n_item.out_byte = 8'h30 + {4'd0, di};
                end else if (k < 6'd18) n_item.out_byte = " ";
                else if (k < 6'd28) n_item.out_byte = "0";
                else if (k == 6'd28) n_item.out_byte = {7'h18, r_cmd.tx_state};
                else if (k == 6'd29) n_item.out_byte = "1";
                else if (k < 6'd36) n_item.out_byte = "0";
                else if (k == 6'd36) n_item.out_byte = " ";
                else n_item.out_byte = ";";
            end
            default: begin
                if (k == 6'd0) n_item.out_byte = "?";
                else if (k == 6'd1) n_item.out_byte = ";";
                else n_item.out_byte = 8'h0A;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take) r_cmd <= i_cmd;
        if (r_state == ST_PARSE) begin
            r_val <= r_cmd.freq;
            r_dcnt <= 4'(FreqDigits - 1);
            r_len <= len;
        end
        if (r_state == ST_CONV) begin
            r_dig[r_dcnt] <= rem;
            r_val <= q;
            r_dcnt <= r_dcnt - 4'd1;
        end
        if (r_state == ST_EMIT && out_free) r_item <= n_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EMIT && out_free) begin
                r_valid <= 1'b1;
                r_idx <= (n_state == ST_IDLE) ? 6'd0 : r_idx + 6'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_item = r_item;

`ifndef NO_ASSERTIONS
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> r_idx < r_len) else $error("index past length");
    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> r_idx == 6'd0) else $error("index not cleared");
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT && out_free && r_idx == r_len - 6'd1 |=>
        r_valid && r_item.last) else $error("last missing");
`endif
endmodule

@@ hw/rtl/cat_command_parser_unit.sv @@
// a plain byte is taken and gives no beat
// a ';' gives its first beat after handoff, setup and an 11-step divide-by-ten
// loop in the back part, then one beat per cycle unless stalled, up to 38 beats
// a new byte is taken while the back part works, one pending command queued
// synchronous active-low reset clears fill count, transmit state and handshakes
`timescale 1ns / 1ps
module cat_command_parser_unit import ccp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    logic cmd_valid, cmd_stall;
    t_cmd cmd;

    ccp_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item,
        .o_cmd_valid(cmd_valid), .i_cmd_stall(cmd_stall), .o_cmd(cmd)
    );
    ccp_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_stall(cmd_stall),
        .i_cmd(cmd), .o_valid, .i_stall, .o_item
    );
endmodule
